@@ hdl/accel_offset_calibrate_filter_average_defines.svh @@
// Assertion macros for the accelerometer offset calibration block.
// Needs clk and arst_n in the scope of each use.
`ifndef ACCEL_OFFSET_CALIBRATE_FILTER_AVERAGE_DEFINES_SVH
`define ACCEL_OFFSET_CALIBRATE_FILTER_AVERAGE_DEFINES_SVH

// same-cycle implication
`define AOCFA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AOCFA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/aocfa_pkg.sv @@
// Shared types and constants of the accelerometer offset calibration block.
// No dependencies.
package aocfa_pkg;

	localparam int CAL_CYCLES_DEF     = 512;
	localparam int FLIGHT_SAMPLES_DEF = 50;
	localparam int MEAN_COUNT_MAX_DEF = 65535;

	localparam logic        FILTER_EN_RST = 1'b1;
	localparam logic [15:0] FILTER_GAIN_RST = 16'd5000;
	localparam logic [14:0] ONE_G_RST = 15'd256;
	localparam logic        INFLIGHT_EN_RST = 1'b0;

	typedef enum logic [2:0] {
		OP_SAMPLE = 3'd0,
		OP_GROUND = 3'd1,
		OP_FLIGHT = 3'd2,
		OP_COMMIT = 3'd3,
		OP_READ   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		REG_FILTER_EN   = 2'd0,
		REG_FILTER_GAIN = 2'd1,
		REG_ONE_G       = 2'd2,
		REG_INFLIGHT_EN = 2'd3
	} reg_t;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [15:0] sample_x;
		logic signed [15:0] sample_y;
		logic signed [15:0] sample_z;
	} in_t;

	typedef struct packed {
		logic signed [15:0] corr_x;
		logic signed [15:0] corr_y;
		logic signed [15:0] corr_z;
		logic               ground_cal_idle;
		logic               inflight_measured;
		logic signed [15:0] avg_x;
		logic signed [15:0] avg_y;
		logic signed [15:0] avg_z;
		logic               avg_valid;
	} out_t;

	function automatic int max3(input int a, input int b, input int c);
		int m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

endpackage

@@ hdl/aocfa_div.sv @@
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Uses aocfa_pkg; quotient truncated toward zero.
module aocfa_div
	import aocfa_pkg::*;
#(
	parameter int DDW = 33,
	parameter int DVW = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [DDW-1:0] dividend,
	input  logic [DVW-1:0]        divisor,
	output logic                  done,
	output logic signed [DDW-1:0] quotient
);

	localparam int CW = $clog2(DDW + 1);

	logic           busy_q, done_q, neg_q;
	logic [CW-1:0]  cnt_q;
	logic [DDW-1:0] quo_q;
	logic [DVW-1:0] rem_q, dvs_q;
	logic [DVW:0]   rem_sh;
	logic           fits;

	// restoring step
	assign rem_sh = {rem_q, quo_q[DDW-1]};
	assign fits = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DDW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DDW-1];
			quo_q <= dividend[DDW-1] ? DDW'(-dividend) : dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DVW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVW-1:0];
			quo_q <= {quo_q[DDW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

@@ hdl/accel_offset_calibrate_filter_average.sv @@
// Three-axis accelerometer offset calibration with a first-order low-pass
// filter and a read-and-clear average. One beat is taken at a time: with the
// filter on, a sample passes through the one shared multiplier axis by axis
// (states S_MUL and S_ACC); with it off it skips them. The last ground
// calibration sample, a commit (in-flight enabled, no ground calibration
// running) and an average read (mean count not zero) each add three passes
// of the shared serial divider. Other commands go straight to the output
// register. A result may wait at the output while the next beat is taken in.
// Uses aocfa_pkg, aocfa_div and the assertion macro header.
`include "accel_offset_calibrate_filter_average_defines.svh"

module accel_offset_calibrate_filter_average
	import aocfa_pkg::*;
#(
	parameter int CAL_CYCLES     = CAL_CYCLES_DEF,
	parameter int FLIGHT_SAMPLES = FLIGHT_SAMPLES_DEF,
	parameter int MEAN_COUNT_MAX = MEAN_COUNT_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	localparam int GCW = $clog2(CAL_CYCLES + 1);
	localparam int FCW = $clog2(FLIGHT_SAMPLES + 1);
	localparam int MCW = $clog2(MEAN_COUNT_MAX + 1);
	localparam int GW  = 16 + GCW;
	localparam int FW  = 16 + FCW;
	localparam int MW  = 17 + MCW;
	localparam int DDW = max3(GW, FW, MW);
	localparam int DVW = max3(GCW, FCW, MCW);
	localparam int QW  = DDW + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_ACC, S_SAMPLE, S_DSTART, S_DWAIT, S_DONE
	} state_t;

	typedef enum logic [1:0] {
		SRC_GROUND, SRC_FLIGHT, SRC_MEAN
	} src_t;

	state_t state_q;
	src_t   src_q;
	logic [1:0] ax_q;

	logic        filter_en_q, inflight_en_q;
	logic [15:0] gain_q;
	logic [14:0] one_g_q;

	logic signed [31:0]   lpf_q [3];
	logic signed [15:0]   f_q [3];
	logic signed [15:0]   trim_q [3];
	logic signed [15:0]   saved_q [3];
	logic signed [GW-1:0] gsum_q [3];
	logic signed [FW-1:0] fsum_q [3];
	logic signed [MW-1:0] msum_q [3];
	logic [GCW-1:0] gcnt_q;
	logic [FCW-1:0] fcnt_q;
	logic [MCW-1:0] mcnt_q;
	logic signed [49:0] p_q;

	out_t res_q, out_q;
	logic out_valid_q;

	logic signed [32:0] diff;
	logic signed [49:0] p_rnd;
	logic signed [31:0] st_new;
	logic signed [32:0] st_rnd;

	logic signed [GW-1:0] gsum_c [3];
	logic signed [FW-1:0] fsum_c [3];
	logic signed [15:0]   corr_c [3];
	logic signed [16:0]   cdiff [3];

	logic                  div_start, div_done;
	logic signed [DDW-1:0] div_a, div_q;
	logic [DVW-1:0]        div_b;
	logic signed [QW-1:0]  trim_wide;

	function automatic logic signed [15:0] sat16(input logic signed [QW-1:0] v);
		if ((&v[QW-1:15]) || !(|v[QW-1:15]))
			return v[15:0];
		return v[QW-1] ? 16'sh8000 : 16'sh7fff;
	endfunction

	// filter arithmetic for the current axis; step is floored
	assign diff = {f_q[ax_q][15], f_q[ax_q], 16'b0} - {lpf_q[ax_q][31], lpf_q[ax_q]};
	assign p_rnd = p_q >>> 16;
	assign st_new = lpf_q[ax_q] + p_rnd[31:0];
	assign st_rnd = {st_new[31], st_new} + (st_new[31] ? 33'sd65535 : 33'sd0);

	// per-axis sums and correction
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			gsum_c[i] = ((gcnt_q == GCW'(CAL_CYCLES)) ? '0 : gsum_q[i])
				+ {{(GW-16){f_q[i][15]}}, f_q[i]};
			fsum_c[i] = ((fcnt_q == FCW'(FLIGHT_SAMPLES)) ? '0 : fsum_q[i])
				+ {{(FW-16){f_q[i][15]}}, f_q[i]};
			cdiff[i] = {f_q[i][15], f_q[i]} - {trim_q[i][15], trim_q[i]};
			corr_c[i] = sat16({{(QW-17){cdiff[i][16]}}, cdiff[i]});
		end
	end

	// divider operand select
	always_comb begin
		unique case (src_q)
			SRC_GROUND: begin
				div_a = {{(DDW-GW){gsum_q[ax_q][GW-1]}}, gsum_q[ax_q]};
				div_b = DVW'(CAL_CYCLES);
			end
			SRC_FLIGHT: begin
				div_a = {{(DDW-FW){fsum_q[ax_q][FW-1]}}, fsum_q[ax_q]};
				div_b = DVW'(FLIGHT_SAMPLES);
			end
			default: begin
				div_a = {{(DDW-MW){msum_q[ax_q][MW-1]}}, msum_q[ax_q]};
				div_b = {{(DVW-MCW){1'b0}}, mcnt_q};
			end
		endcase
	end

	assign div_start = state_q == S_DSTART;
	assign trim_wide = {div_q[DDW-1], div_q}
		- ((ax_q == 2'd2) ? {{(QW-15){1'b0}}, one_g_q} : '0);

	aocfa_div #(.DDW(DDW), .DVW(DVW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_en_q <= FILTER_EN_RST;
			gain_q <= FILTER_GAIN_RST;
			one_g_q <= ONE_G_RST;
			inflight_en_q <= INFLIGHT_EN_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_FILTER_EN:   filter_en_q <= cfg_wdata[0];
				REG_FILTER_GAIN: gain_q <= cfg_wdata;
				REG_ONE_G:       one_g_q <= cfg_wdata[14:0];
				default:         inflight_en_q <= cfg_wdata[0];
			endcase
		end
	end

	// sequencer, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			src_q <= SRC_GROUND;
			ax_q <= '0;
			gcnt_q <= '0;
			fcnt_q <= '0;
			mcnt_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				lpf_q[i] <= '0;
				trim_q[i] <= '0;
				saved_q[i] <= '0;
				gsum_q[i] <= '0;
				fsum_q[i] <= '0;
				msum_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						res_q <= '0;
						ax_q <= '0;
						f_q[0] <= in_data.sample_x;
						f_q[1] <= in_data.sample_y;
						f_q[2] <= in_data.sample_z;
						state_q <= S_DONE;
						unique case (in_data.opcode)
							OP_SAMPLE: state_q <= filter_en_q ? S_MUL : S_SAMPLE;
							OP_GROUND: gcnt_q <= GCW'(CAL_CYCLES);
							OP_FLIGHT: begin
								if (inflight_en_q && fcnt_q == '0)
									fcnt_q <= FCW'(FLIGHT_SAMPLES);
							end
							OP_COMMIT: begin
								if (inflight_en_q && gcnt_q == '0) begin
									src_q <= SRC_FLIGHT;
									state_q <= S_DSTART;
								end
							end
							OP_READ: begin
								if (mcnt_q != '0) begin
									src_q <= SRC_MEAN;
									state_q <= S_DSTART;
								end
							end
							default: ;
						endcase
					end
				end
				S_MUL: begin
					p_q <= $signed({1'b0, gain_q}) * diff;
					state_q <= S_ACC;
				end
				S_ACC: begin
					lpf_q[ax_q] <= st_new;
					f_q[ax_q] <= st_rnd[31:16];
					if (ax_q == 2'd2) begin
						state_q <= S_SAMPLE;
					end else begin
						ax_q <= ax_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				S_SAMPLE: begin
					ax_q <= '0;
					state_q <= S_DONE;
					if (gcnt_q != '0) begin
						// ground calibration consumes the sample
						for (int i = 0; i < 3; i++) begin
							gsum_q[i] <= gsum_c[i];
							trim_q[i] <= '0;
						end
						gcnt_q <= gcnt_q - 1'b1;
						if (gcnt_q == GCW'(1)) begin
							src_q <= SRC_GROUND;
							state_q <= S_DSTART;
						end
					end else if (inflight_en_q && fcnt_q != '0) begin
						// in-flight measurement keeps the old trims aside
						for (int i = 0; i < 3; i++) begin
							if (fcnt_q == FCW'(FLIGHT_SAMPLES))
								saved_q[i] <= trim_q[i];
							fsum_q[i] <= fsum_c[i];
							trim_q[i] <= (fcnt_q == FCW'(1)) ? saved_q[i] : '0;
						end
						res_q.inflight_measured <= fcnt_q == FCW'(1);
						fcnt_q <= fcnt_q - 1'b1;
					end else begin
						res_q.corr_x <= corr_c[0];
						res_q.corr_y <= corr_c[1];
						res_q.corr_z <= corr_c[2];
					end
					// running mean; calibrating samples add zero
					if (mcnt_q < MCW'(MEAN_COUNT_MAX)) begin
						mcnt_q <= mcnt_q + 1'b1;
						if (gcnt_q == '0 && !(inflight_en_q && fcnt_q != '0)) begin
							for (int i = 0; i < 3; i++)
								msum_q[i] <= msum_q[i]
									+ {{(MW-16){corr_c[i][15]}}, corr_c[i]};
						end
					end
				end
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_done) begin
						if (src_q == SRC_MEAN) begin
							msum_q[ax_q] <= '0;
							unique case (ax_q)
								2'd0: res_q.avg_x <= sat16({div_q[DDW-1], div_q});
								2'd1: res_q.avg_y <= sat16({div_q[DDW-1], div_q});
								default: res_q.avg_z <= sat16({div_q[DDW-1], div_q});
							endcase
						end else begin
							trim_q[ax_q] <= sat16(trim_wide);
						end
						if (ax_q == 2'd2) begin
							if (src_q == SRC_MEAN) begin
								mcnt_q <= '0;
								res_q.avg_valid <= 1'b1;
							end
							state_q <= S_DONE;
						end else begin
							ax_q <= ax_q + 1'b1;
							state_q <= S_DSTART;
						end
					end
				end
				default: begin
					// S_DONE: hand the result to the output register
					if (!out_valid_q || !out_stall) begin
						out_q <= res_q;
						out_q.ground_cal_idle <= gcnt_q == '0;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign in_stall = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`AOCFA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accept not busy")
	`AOCFA_ASSERT_NOW(a_read_no_corr, out_valid && out_data.avg_valid, out_data.corr_x == 16'sd0 && out_data.corr_y == 16'sd0 && out_data.corr_z == 16'sd0, "read with corr")
	`AOCFA_ASSERT_NOW(a_meas_no_corr, out_valid && out_data.inflight_measured, out_data.corr_x == 16'sd0 && out_data.corr_z == 16'sd0 && !out_data.avg_valid, "measured with corr")
	`AOCFA_ASSERT_NOW(a_div_only_wait, div_done, state_q == S_DWAIT, "divider done outside wait")

endmodule
